/* rtl/thp_pkg.sv */
// ----------------------------------------------------------------------------
// thp_pkg
// shared constants and helper functions for the hydrogen placement pipeline
// ----------------------------------------------------------------------------
package thp_pkg;

  localparam int SHW = 6;

  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] b;
    n   = v;
    res = '0;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  localparam logic [63:0] K1_FULL = isqrt_c((64'd1 << 60) / 64'd3);
  localparam logic [63:0] K2_FULL = isqrt_c((64'd1 << 61) / 64'd3);
  localparam logic [30:0] K1 = K1_FULL[30:0];
  localparam logic [30:0] K2 = K2_FULL[30:0];

  // latency of one normalise unit
  function automatic int norm_lat(input int fb);
    return fb + 40;
  endfunction

  // round half away from zero of x / 2^k
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] x, input int k);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    m = (m + (64'd1 << (k - 1))) >> k;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/thp_delay.sv */
// ----------------------------------------------------------------------------
// thp_delay
// stall-aware shift line that carries sideband alongside the pipeline
// ----------------------------------------------------------------------------
module thp_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) line_r[i] <= '0;
    end else if (en) begin
      line_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) line_r[i] <= line_r[i-1];
    end
  end

  assign q = line_r[DEPTH-1];

endmodule

/* rtl/thp_norm.sv */
// ----------------------------------------------------------------------------
// thp_norm
// pipelined vector normalise: range shift, sum of squares, bit-per-stage
// square root and bit-per-stage rounding divide
// ----------------------------------------------------------------------------
module thp_norm import thp_pkg::*; #(
  parameter int DW = 33,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] d [3],
  output logic signed [FB+1:0] u [3],
  output logic                 ok
);

  localparam int QW = FB + 2;
  localparam int RW = FB + 33;

  // magnitudes and largest magnitude
  logic [DW-1:0] mag [3];
  logic [DW-1:0] top;

  always_comb begin
    for (int i = 0; i < 3; i++) mag[i] = d[i][DW-1] ? DW'(-d[i]) : DW'(d[i]);
    top = mag[0];
    if (mag[1] > top) top = mag[1];
    if (mag[2] > top) top = mag[2];
  end

  logic [DW-1:0] m1_r [3];
  logic [2:0]    n1_r;
  logic [DW-1:0] top1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i] <= mag[i];
        n1_r[i] <= d[i][DW-1];
      end
      top1_r <= top;
    end
  end

  // leading one of the largest magnitude
  logic [SHW-1:0] rsh_nxt, lsh_nxt;

  always_comb begin
    int p;
    p = 0;
    for (int b = 0; b < DW; b++) if (top1_r[b]) p = b;
    rsh_nxt = (p > 29) ? SHW'(p - 29) : '0;
    lsh_nxt = (p < 29) ? SHW'(29 - p) : '0;
  end

  logic [DW-1:0]  m2_r [3];
  logic [2:0]     n2_r;
  logic           z2_r;
  logic [SHW-1:0] rsh2_r, lsh2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r   <= m1_r;
      n2_r   <= n1_r;
      z2_r   <= (top1_r == '0);
      rsh2_r <= rsh_nxt;
      lsh2_r <= lsh_nxt;
    end
  end

  // range shift: largest magnitude into [2^29, 2^30)
  logic [2:0][29:0] m3_nxt;

  always_comb begin
    logic [DW+29:0] t;
    t = '0;
    for (int i = 0; i < 3; i++) begin
      t         = {30'b0, m2_r[i]} >> rsh2_r;
      t         = t << lsh2_r;
      m3_nxt[i] = t[29:0];
    end
  end

  logic [2:0][29:0] m3_r, m4_r, m5_r;
  logic [2:0]       n3_r, n4_r, n5_r;
  logic             z3_r, z4_r, z5_r;
  logic [59:0]      sq4_r [3];
  logic [63:0]      sum5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r <= m3_nxt;
      n3_r <= n2_r;
      z3_r <= z2_r;
      for (int i = 0; i < 3; i++) sq4_r[i] <= 60'(m3_r[i]) * 60'(m3_r[i]);
      m4_r   <= m3_r;
      n4_r   <= n3_r;
      z4_r   <= z3_r;
      sum5_r <= 64'(sq4_r[0]) + 64'(sq4_r[1]) + 64'(sq4_r[2]);
      m5_r   <= m4_r;
      n5_r   <= n4_r;
      z5_r   <= z4_r;
    end
  end

  // square root, one result bit per stage
  logic [63:0]      qn [0:31];
  logic [63:0]      qs [0:32];
  logic [2:0][29:0] qm [0:32];
  logic [2:0]       qg [0:32];
  logic             qz [0:32];

  assign qn[0] = sum5_r;
  assign qs[0] = '0;
  assign qm[0] = m5_r;
  assign qg[0] = n5_r;
  assign qz[0] = z5_r;

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]      rem_nxt, res_nxt, res_r;
    logic [2:0][29:0] m_r;
    logic [2:0]       g_r;
    logic             z_r;

    always_comb begin
      if (qn[k] >= qs[k] + BIT) begin
        rem_nxt = qn[k] - (qs[k] + BIT);
        res_nxt = (qs[k] >> 1) + BIT;
      end else begin
        rem_nxt = qn[k];
        res_nxt = qs[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res_r <= res_nxt;
        m_r   <= qm[k];
        g_r   <= qg[k];
        z_r   <= qz[k];
      end
    end

    if (k < 31) begin : g_rem
      logic [63:0] rem_r;
      always_ff @(posedge clk) begin
        if (en) rem_r <= rem_nxt;
      end
      assign qn[k+1] = rem_r;
    end

    assign qs[k+1] = res_r;
    assign qm[k+1] = m_r;
    assign qg[k+1] = g_r;
    assign qz[k+1] = z_r;
  end

  // rounding divide, one quotient bit per stage
  logic [2:0][RW-1:0] dr [0:QW-1];
  logic [31:0]        dd [0:QW-1];
  logic [2:0][QW-1:0] dq [0:QW];
  logic [2:0]         dg [0:QW];
  logic               dz [0:QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dr[0][i] = RW'({qm[32][i], {(FB + 1){1'b0}}}) + RW'(qs[32][30:0]);
    end
  end

  assign dd[0] = {qs[32][30:0], 1'b0};
  assign dq[0] = '0;
  assign dg[0] = qg[32];
  assign dz[0] = qz[32];

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [RW-1:0]      dsh;
    logic [2:0][RW-1:0] r_nxt;
    logic [2:0][QW-1:0] q_nxt, q_r;
    logic [2:0]         g_r;
    logic               z_r;

    always_comb begin
      dsh = RW'(dd[j]) << SH;
      for (int i = 0; i < 3; i++) begin
        q_nxt[i] = dq[j][i];
        r_nxt[i] = dr[j][i];
        if (dr[j][i] >= dsh) begin
          r_nxt[i]     = dr[j][i] - dsh;
          q_nxt[i][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r <= q_nxt;
        g_r <= dg[j];
        z_r <= dz[j];
      end
    end

    if (j < QW - 1) begin : g_rem
      logic [2:0][RW-1:0] r_r;
      logic [31:0]        d_r;
      always_ff @(posedge clk) begin
        if (en) begin
          r_r <= r_nxt;
          d_r <= dd[j];
        end
      end
      assign dr[j+1] = r_r;
      assign dd[j+1] = d_r;
    end

    assign dq[j+1] = q_r;
    assign dg[j+1] = g_r;
    assign dz[j+1] = z_r;
  end

  logic signed [FB+1:0] u_r [3];
  logic                 ok_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dz[QW]) begin
          u_r[i] <= '0;
        end else if (dg[QW][i]) begin
          u_r[i] <= -$signed(dq[QW][i]);
        end else begin
          u_r[i] <= $signed(dq[QW][i]);
        end
      end
      ok_r <= !dz[QW];
    end
  end

  assign u  = u_r;
  assign ok = ok_r;

endmodule

/* rtl/tetrahedral_hydrogen_placement_core.sv */
// ----------------------------------------------------------------------------
// tetrahedral_hydrogen_placement_core
// places two hydrogens tetrahedrally on a centre atom with two neighbours
// ----------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle unless the result side
// stalls. Data passes through two normalise units in series, each with a
// 32-stage square root and a FRAC_BITS+2 stage divide. A stall on the
// result side holds the whole pipeline; in_tready drops only while a result
// waits and out_tready is low.
module tetrahedral_hydrogen_placement_core import thp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // centre_x/y/z, first_nb_x/y/z, second_nb_x/y/z, bond_len_a, bond_len_b, pad
  input  logic [351:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hyd_a_x/y/z, hyd_b_x/y/z
  output logic [191:0] out_tdata,
  // degenerate
  output logic [0:0]   out_tuser
);

  localparam int UW  = FRAC_BITS + 2;
  localparam int SW  = UW + 1;
  localparam int XW  = 2 * UW + 1;
  localparam int MW  = UW + 32;
  localparam int BW  = UW + 1;
  localparam int PW  = BW + 32;
  localparam int NL  = norm_lat(FRAC_BITS);
  localparam int SBW = 1 + 96 + 62;

  logic en;
  logic out_tvalid_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // input stage: differences to the centre
  logic               s0_v_r;
  logic signed [31:0] s0_c_r [3];
  logic signed [32:0] s0_a_r [3];
  logic signed [32:0] s0_b_r [3];
  logic [30:0]        s0_ra_r, s0_rb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_c_r[i] <= $signed(in_tdata[32*i +: 32]);
        s0_a_r[i] <= 33'($signed(in_tdata[96 + 32*i +: 32]))
                     - 33'($signed(in_tdata[32*i +: 32]));
        s0_b_r[i] <= 33'($signed(in_tdata[192 + 32*i +: 32]))
                     - 33'($signed(in_tdata[32*i +: 32]));
      end
      s0_ra_r <= in_tdata[318:288];
      s0_rb_r <= in_tdata[349:319];
    end
  end

  // sideband: valid, centre and bond lengths
  logic [SBW-1:0] sb_d;
  logic           r_v;
  logic [31:0]    r_c [3];
  logic [30:0]    r_ra, r_rb;

  thp_delay #(.W(SBW), .DEPTH(2 * NL + 4)) u_sb (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     ({s0_v_r, s0_c_r[2], s0_c_r[1], s0_c_r[0], s0_rb_r, s0_ra_r}),
    .q     (sb_d)
  );

  assign {r_v, r_c[2], r_c[1], r_c[0], r_rb, r_ra} = sb_d;

  // unit vectors to the neighbours
  logic signed [UW-1:0] ua [3];
  logic signed [UW-1:0] ub [3];
  logic                 ok_a, ok_b;

  thp_norm #(.DW(33), .FB(FRAC_BITS)) u_norm_a (
    .clk (clk), .en (en), .d (s0_a_r), .u (ua), .ok (ok_a)
  );

  thp_norm #(.DW(33), .FB(FRAC_BITS)) u_norm_b (
    .clk (clk), .en (en), .d (s0_b_r), .u (ub), .ok (ok_b)
  );

  // cross products and sum
  logic signed [2*UW-1:0] pr_r [6];
  logic signed [SW-1:0]   sum_r [3];
  logic signed [SW-1:0]   sq_r [3];
  logic signed [XW-1:0]   x_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r[0] <= ua[1] * ub[2];
      pr_r[1] <= ua[2] * ub[1];
      pr_r[2] <= ua[2] * ub[0];
      pr_r[3] <= ua[0] * ub[2];
      pr_r[4] <= ua[0] * ub[1];
      pr_r[5] <= ua[1] * ub[0];
      for (int i = 0; i < 3; i++) sum_r[i] <= SW'(ua[i]) + SW'(ub[i]);
      x_r[0] <= XW'(pr_r[0]) - XW'(pr_r[1]);
      x_r[1] <= XW'(pr_r[2]) - XW'(pr_r[3]);
      x_r[2] <= XW'(pr_r[4]) - XW'(pr_r[5]);
      sq_r   <= sum_r;
    end
  end

  logic ok12_d;

  thp_delay #(.W(1), .DEPTH(NL + 4)) u_ok12 (
    .clk (clk), .rst_n (rst_n), .en (en), .d (ok_a & ok_b), .q (ok12_d)
  );

  // back and side directions
  logic signed [UW-1:0] nv [3];
  logic signed [UW-1:0] wv [3];
  logic                 ok_s, ok_x, ok34_d;

  thp_norm #(.DW(SW), .FB(FRAC_BITS)) u_norm_s (
    .clk (clk), .en (en), .d (sq_r), .u (nv), .ok (ok_s)
  );

  thp_norm #(.DW(XW), .FB(FRAC_BITS)) u_norm_x (
    .clk (clk), .en (en), .d (x_r), .u (wv), .ok (ok_x)
  );

  thp_delay #(.W(1), .DEPTH(2)) u_ok34 (
    .clk (clk), .rst_n (rst_n), .en (en), .d (ok_s & ok_x), .q (ok34_d)
  );

  logic signed [MW-1:0] nk_r [3];
  logic signed [MW-1:0] wk_r [3];
  logic signed [BW-1:0] bs_r [3];
  logic signed [BW-1:0] bd_r [3];
  logic signed [63:0]   back_c [3];
  logic signed [63:0]   side_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      back_c[i] = -rnd_sh(64'(nk_r[i]), 30);
      side_c[i] = rnd_sh(64'(wk_r[i]), 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nk_r[i] <= MW'(nv[i]) * MW'($signed({1'b0, K1}));
        wk_r[i] <= MW'(wv[i]) * MW'($signed({1'b0, K2}));
        bs_r[i] <= BW'(back_c[i] + side_c[i]);
        bd_r[i] <= BW'(back_c[i] - side_c[i]);
      end
    end
  end

  // bond scaling
  logic                 y_v_r;
  logic                 y_deg_r;
  logic signed [31:0]   y_c_r [3];
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_v_r <= 1'b0;
    end else if (en) begin
      y_v_r <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_deg_r <= !(ok12_d && ok34_d);
      for (int i = 0; i < 3; i++) begin
        y_c_r[i] <= $signed(r_c[i]);
        pa_r[i]  <= PW'(bs_r[i]) * PW'($signed({1'b0, r_ra}));
        pb_r[i]  <= PW'(bd_r[i]) * PW'($signed({1'b0, r_rb}));
      end
    end
  end

  // final offset, saturation, degenerate fallback to the centre and result register
  logic [191:0] res_c;
  logic [191:0] out_tdata_r;
  logic         out_tuser_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (y_deg_r) begin
        res_c[32*i +: 32]      = y_c_r[i];
        res_c[96 + 32*i +: 32] = y_c_r[i];
      end else begin
        res_c[32*i +: 32]      = sat32(64'(y_c_r[i]) + rnd_sh(64'(pa_r[i]), FRAC_BITS));
        res_c[96 + 32*i +: 32] = sat32(64'(y_c_r[i]) + rnd_sh(64'(pb_r[i]), FRAC_BITS));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= y_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= res_c;
      out_tuser_r <= y_deg_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

`ifndef ASSERT_OFF
  a_deg_same : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[95:0] == out_tdata[191:96])
    else $error("degenerate result with differing hydrogens");

  a_adv : assert property (@(posedge clk) disable iff (!rst_n)
    en && y_v_r |=> out_tvalid)
    else $error("pipeline result lost at output register");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(y_v_r) && $stable(s0_v_r))
    else $error("pipeline moved during stall");

  a_rst : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
`endif

endmodule
